// ===== hdl/ppcs_pkg.sv =====
package ppcs_pkg;

  // Default widths
  localparam int COUNT_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration port widths
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 16;
  localparam int THR_W      = 12;
  localparam int PCOUNT_W   = 16;

  // Reset thresholds: 0.1 V and 0.60 V on a 3.3 V, 4095-code converter
  localparam logic [THR_W-1:0] LIFT_THR_RST  = 12'd124;
  localparam logic [THR_W-1:0] PEDAL_THR_RST = 12'd745;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_COUNT  = 3'd0,
    REG_END_COUNT    = 3'd1,
    REG_CUT_TIME     = 3'd2,
    REG_SUCTION_TIME = 3'd3,
    REG_START_EN     = 3'd4,
    REG_END_EN       = 3'd5,
    REG_LIFT_THR     = 3'd6,
    REG_PEDAL_THR    = 3'd7
  } cfg_reg_t;

  // Solenoid sequence phases
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_RELAY = 6'b000010,
    PH_CUT   = 6'b000100,
    PH_GAP   = 6'b001000,
    PH_SUCK  = 6'b010000,
    PH_TAIL  = 6'b100000
  } phase_t;

  // Lifter hysteresis mode
  typedef enum logic [2:0] {
    LIFT_NONE     = 3'b001,
    LIFT_ENGAGED  = 3'b010,
    LIFT_RELEASED = 3'b100
  } lift_t;

endpackage

// ===== hdl/pulse_position_cutter_sequencer.sv =====
// An accepted request's result is registered in the output register in the next cycle.
// Throughput: one request per cycle while the output is not stalled; all per-tick work is a single combinational
//   pass from the state registers and input ports into the state and result registers.
// Reset (rst_n low, synchronous): sequencer idle, counters and latches cleared,
//   thresholds at their default codes, output register empty.
module pulse_position_cutter_sequencer #(
  parameter int COUNT_BITS  = ppcs_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = ppcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [ppcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ppcs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_hall_edge,
  input  logic                              in_photo_level,
  input  logic [SAMPLE_BITS-1:0]            in_pedal_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_cutter_drive,
  output logic                              out_suction_drive,
  output logic                              out_lifter_drive,
  output logic                              out_relay_drive,
  output logic [ppcs_pkg::PCOUNT_W-1:0]     out_pulse_count,
  output logic                              out_object_present,
  output logic                              out_busy_res
);
  import ppcs_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;

  // Configuration registers
  logic [TIME_W-1:0] start_count_r, end_count_r, cut_time_r, suction_time_r;
  logic              start_en_r, end_en_r;
  logic [THR_W-1:0]  lift_thr_r, pedal_thr_r;

  // Sequencer state
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  obj_r, obj_nxt;
  logic                  cut_done_r, cut_done_nxt;
  logic                  pedal_latch_r, pedal_latch_nxt;
  logic                  suct_used_r, suct_used_nxt;
  lift_t                 lift_mode_r, lift_mode_nxt;
  logic                  relay_r, relay_nxt;
  logic                  lifter_r, lifter_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIME_W-1:0]     timer_r, timer_nxt;
  logic                  hall_pend_r, hall_pend_nxt;
  logic                  pedal_q_r, pedal_q_nxt;

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic cutter_r, suction_r, busy_r;

  logic                   in_accept;
  logic [SAMPLE_BITS-1:0] lthr, pthr;
  logic                   cut_hit;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign lthr      = SAMPLE_BITS'(lift_thr_r);
  assign pthr      = SAMPLE_BITS'(pedal_thr_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_count_r  <= '0;
      end_count_r    <= '0;
      cut_time_r     <= '0;
      suction_time_r <= '0;
      start_en_r     <= 1'b0;
      end_en_r       <= 1'b0;
      lift_thr_r     <= LIFT_THR_RST;
      pedal_thr_r    <= PEDAL_THR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_COUNT:  start_count_r  <= cfg_wdata;
        REG_END_COUNT:    end_count_r    <= cfg_wdata;
        REG_CUT_TIME:     cut_time_r     <= cfg_wdata;
        REG_SUCTION_TIME: suction_time_r <= cfg_wdata;
        REG_START_EN:     start_en_r     <= cfg_wdata[0];
        REG_END_EN:       end_en_r       <= cfg_wdata[0];
        REG_LIFT_THR:     lift_thr_r     <= cfg_wdata[THR_W-1:0];
        REG_PEDAL_THR:    pedal_thr_r    <= cfg_wdata[THR_W-1:0];
        default:          ;
      endcase
    end
  end

  // One tick of the sequencer
  always_comb begin
    logic hall, idle, fire;
    hall            = in_hall_edge;
    idle            = 1'b1;
    fire            = 1'b0;
    cut_hit         = 1'b0;
    cnt_nxt         = cnt_r;
    obj_nxt         = obj_r;
    cut_done_nxt    = cut_done_r;
    pedal_latch_nxt = pedal_latch_r;
    suct_used_nxt   = suct_used_r;
    lift_mode_nxt   = lift_mode_r;
    relay_nxt       = relay_r;
    lifter_nxt      = lifter_r;
    phase_nxt       = phase_r;
    timer_nxt       = timer_r;
    hall_pend_nxt   = hall_pend_r;
    pedal_q_nxt     = pedal_q_r;

    // Busy tick: count down the running phase, remember hall edges
    if (phase_r != PH_IDLE) begin
      if (hall) hall_pend_nxt = 1'b1;
      timer_nxt = timer_r - TIME_W'(1);
      if (timer_nxt == '0) begin
        case (phase_r)
          PH_RELAY: begin
            if (cut_time_r != '0) begin
              phase_nxt = PH_CUT;
              timer_nxt = cut_time_r;
            end else begin
              phase_nxt = PH_GAP;
              timer_nxt = TIME_W'(1);
            end
          end
          PH_CUT: begin
            phase_nxt = PH_GAP;
            timer_nxt = TIME_W'(1);
          end
          PH_GAP: begin
            if (suction_time_r != '0) begin
              phase_nxt = PH_SUCK;
              timer_nxt = suction_time_r;
            end else begin
              phase_nxt = PH_TAIL;
              timer_nxt = TIME_W'(1);
            end
          end
          PH_SUCK: begin
            phase_nxt = PH_TAIL;
            timer_nxt = TIME_W'(1);
          end
          PH_TAIL: begin
            // queued pedal suction runs right after the tail
            if (pedal_q_r) begin
              pedal_q_nxt = 1'b0;
              if (suction_time_r != '0) begin
                phase_nxt = PH_SUCK;
                timer_nxt = suction_time_r;
              end else begin
                phase_nxt = PH_TAIL;
                timer_nxt = TIME_W'(1);
              end
            end else begin
              phase_nxt = PH_IDLE;
              timer_nxt = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
          end
        endcase
      end
      if (phase_nxt != PH_IDLE) idle = 1'b0;
      else hall = 1'b0;
    end

    if (idle) begin
      // pulse counter and photo latch
      hall          = hall | hall_pend_nxt;
      hall_pend_nxt = 1'b0;
      if (hall && cnt_nxt != '1) cnt_nxt = cnt_nxt + COUNT_BITS'(1);
      if (in_photo_level != obj_nxt) begin
        obj_nxt = in_photo_level;
        cnt_nxt = '0;
      end

      // lifter hysteresis
      if (in_pedal_sample <= lthr) begin
        if (lift_mode_nxt != LIFT_ENGAGED) begin
          lift_mode_nxt = LIFT_ENGAGED;
          suct_used_nxt = 1'b0;
          lifter_nxt    = 1'b1;
          relay_nxt     = 1'b0;
        end
      end else if (lift_mode_nxt != LIFT_RELEASED) begin
        lift_mode_nxt = LIFT_RELEASED;
        lifter_nxt    = 1'b0;
      end

      // one-shot cut at start or end count
      cut_hit = (CMP_W'(cnt_nxt) == CMP_W'(start_count_r) && start_en_r && obj_nxt) ||
                (CMP_W'(cnt_nxt) == CMP_W'(end_count_r) && end_en_r && !obj_nxt);
      if (!cut_done_nxt && cut_hit) begin
        cut_done_nxt = 1'b1;
        relay_nxt    = 1'b1;
        phase_nxt    = PH_RELAY;
        timer_nxt    = TIME_W'(1);
      end
      if (cnt_nxt == '0) cut_done_nxt = 1'b0;

      // pedal one-shot suction
      fire = (in_pedal_sample >= pthr) && !pedal_latch_nxt && obj_nxt && !suct_used_nxt;
      if (fire) begin
        pedal_latch_nxt = 1'b1;
        suct_used_nxt   = 1'b1;
        if (phase_nxt != PH_IDLE) begin
          pedal_q_nxt = 1'b1;
        end else if (suction_time_r != '0) begin
          phase_nxt = PH_SUCK;
          timer_nxt = suction_time_r;
        end else begin
          phase_nxt = PH_TAIL;
          timer_nxt = TIME_W'(1);
        end
      end else if (in_pedal_sample < pthr) begin
        pedal_latch_nxt = 1'b0;
      end
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      obj_r         <= 1'b0;
      cut_done_r    <= 1'b0;
      pedal_latch_r <= 1'b0;
      suct_used_r   <= 1'b0;
      lift_mode_r   <= LIFT_NONE;
      relay_r       <= 1'b0;
      lifter_r      <= 1'b0;
      phase_r       <= PH_IDLE;
      timer_r       <= '0;
      hall_pend_r   <= 1'b0;
      pedal_q_r     <= 1'b0;
    end else if (in_accept) begin
      cnt_r         <= cnt_nxt;
      obj_r         <= obj_nxt;
      cut_done_r    <= cut_done_nxt;
      pedal_latch_r <= pedal_latch_nxt;
      suct_used_r   <= suct_used_nxt;
      lift_mode_r   <= lift_mode_nxt;
      relay_r       <= relay_nxt;
      lifter_r      <= lifter_nxt;
      phase_r       <= phase_nxt;
      timer_r       <= timer_nxt;
      hall_pend_r   <= hall_pend_nxt;
      pedal_q_r     <= pedal_q_nxt;
    end
  end

  // Output register valid
  always_comb begin
    if (in_accept) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  // Result payload, taken with each accepted request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cutter_r  <= (phase_nxt == PH_CUT);
      suction_r <= (phase_nxt == PH_SUCK);
      busy_r    <= (phase_nxt != PH_IDLE);
    end
  end

  // State registers already hold the post-tick value while a result is shown
  assign out_valid          = out_valid_r;
  assign out_cutter_drive   = cutter_r;
  assign out_suction_drive  = suction_r;
  assign out_busy_res       = busy_r;
  assign out_lifter_drive   = lifter_r;
  assign out_relay_drive    = relay_r;
  assign out_pulse_count    = PCOUNT_W'(CMP_W'(cnt_r));
  assign out_object_present = obj_r;

  // Checks
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> timer_r != '0)
    else $error("running phase with expired timer");

  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(cutter_r && suction_r))
    else $error("cutter and suction driven together");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (cutter_r || suction_r) |-> busy_r)
    else $error("solenoid driven outside a sequence");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import ppcs_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 3;
  localparam int MAX_REPORTS   = 10;
  localparam logic [PCOUNT_W-1:0] COUNT_TOP = '1;

  // One result of the block, field by field
  typedef struct packed {
    logic                cutter;
    logic                suction;
    logic                lifter;
    logic                relay;
    logic [PCOUNT_W-1:0] count;
    logic                present;
    logic                busy;
  } drive_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  // Directed row: either a register write or a request, optionally with a typed result
  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         idx;
    logic [15:0]      val;
    logic             hall;
    logic             photo;
    logic [THR_W-1:0] smp;
    drive_t           want;
  } row_t;

  typedef struct {
    drive_t      v;
    int unsigned tag;
  } due_t;

  localparam drive_t NO_DRIVE = '0;

  localparam row_t DIR_ROWS [0:30] = '{
    // default settings after reset: no cut enabled
    '{ROW_TYPED, REG_START_COUNT, 16'd0, 1'b0, 1'b0, 12'd0,
      '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0}},
    '{ROW_TYPED, REG_START_COUNT, 16'd0, 1'b1, 1'b0, 12'd4095,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1, 1'b0, 1'b0}},
    // photo change clears the count, lifter engages
    '{ROW_TYPED, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd100,
      '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b1, 1'b0}},
    // pedal suction with zero suction time: straight to the tail
    '{ROW_TYPED, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd2000,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1, 1'b1, 1'b1}},
    // tail ends; held hall edge counts, then photo change clears it
    '{ROW_TYPED, REG_START_COUNT, 16'd0, 1'b1, 1'b0, 12'd0,
      '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0}},
    '{ROW_CFG, REG_START_COUNT,  16'd2, 1'b0, 1'b0, 12'd0, NO_DRIVE},
    '{ROW_CFG, REG_END_COUNT,    16'd0, 1'b0, 1'b0, 12'd0, NO_DRIVE},
    '{ROW_CFG, REG_CUT_TIME,     16'd2, 1'b0, 1'b0, 12'd0, NO_DRIVE},
    '{ROW_CFG, REG_SUCTION_TIME, 16'd1, 1'b0, 1'b0, 12'd0, NO_DRIVE},
    '{ROW_CFG, REG_START_EN,     16'd1, 1'b0, 1'b0, 12'd0, NO_DRIVE},
    '{ROW_CFG, REG_END_EN,       16'd1, 1'b0, 1'b0, 12'd0, NO_DRIVE},
    // end cut at a count of zero, hall edges collapse while busy
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b0, 12'd500,  NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b0, 12'd500,  NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd500,  NO_DRIVE},
    // re-engage the lifter to rearm suction, then cut and pedal on one tick
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd0,    NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd500,  NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b0, 12'd0,    NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b0, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd2048, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b0, 12'd0,    NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b1, 1'b1, 12'd4095, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd0,    NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd1000, NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd500,  NO_DRIVE},
    '{ROW_PREDICT, REG_START_COUNT, 16'd0, 1'b0, 1'b1, 12'd500,  NO_DRIVE}
  };

  logic                  clk;
  logic                  rst_n             = 1'b0;
  logic                  cfg_we            = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr          = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic                  in_hall_edge      = 1'b0;
  logic                  in_photo_level    = 1'b0;
  logic [THR_W-1:0]      in_pedal_sample   = '0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic                  out_cutter_drive;
  logic                  out_suction_drive;
  logic                  out_lifter_drive;
  logic                  out_relay_drive;
  logic [PCOUNT_W-1:0]   out_pulse_count;
  logic                  out_object_present;
  logic                  out_busy_res;

  pulse_position_cutter_sequencer i_dut (.*);

  // Sequencer state as the block should hold it
  logic [PCOUNT_W-1:0] seq_count;
  logic                seq_present, seq_cut_done, seq_pedal_latch, seq_suction_used;
  logic                seq_relay, seq_lifter, seq_hall_pend, seq_pedal_q;
  lift_t               seq_lift;
  phase_t              seq_phase;
  logic [TIME_W-1:0]   seq_timer;

  // Register copy
  logic [PCOUNT_W-1:0] set_start, set_end;
  logic [TIME_W-1:0]   set_cut, set_suck;
  logic                set_start_en, set_end_en;
  logic [THR_W-1:0]    set_lift, set_pedal;

  due_t        drives_due [$];
  int          gap_pct   = 18;
  int          stall_pct = 64;
  int unsigned n_req, n_checked, n_cuts, n_pedal, errors;
  logic [PCOUNT_W-1:0] top_count_seen;
  logic        obj_lvl;

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic clear_sequencer();
    seq_count = '0; seq_present = 1'b0; seq_cut_done = 1'b0; seq_pedal_latch = 1'b0;
    seq_suction_used = 1'b0; seq_relay = 1'b0; seq_lifter = 1'b0;
    seq_hall_pend = 1'b0; seq_pedal_q = 1'b0;
    seq_lift = LIFT_NONE; seq_phase = PH_IDLE; seq_timer = '0;
    set_start = '0; set_end = '0; set_cut = '0; set_suck = '0;
    set_start_en = 1'b0; set_end_en = 1'b0;
    set_lift = LIFT_THR_RST; set_pedal = PEDAL_THR_RST;
  endtask

  // Walk the phase chain, skipping zero-length cutter or suction phases
  function automatic void advance_phase();
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      case (seq_phase)
        PH_RELAY: begin
          seq_phase = PH_CUT;
          if (set_cut != 0) begin
            seq_timer = set_cut;
            settled = 1'b1;
          end
        end
        PH_CUT: begin
          seq_phase = PH_GAP;
          seq_timer = TIME_W'(1);
          settled = 1'b1;
        end
        PH_GAP: begin
          seq_phase = PH_SUCK;
          if (set_suck != 0) begin
            seq_timer = set_suck;
            settled = 1'b1;
          end
        end
        PH_SUCK: begin
          seq_phase = PH_TAIL;
          seq_timer = TIME_W'(1);
          settled = 1'b1;
        end
        default: begin
          // leaving the tail: a queued pedal suction follows directly
          if (seq_pedal_q) begin
            seq_pedal_q = 1'b0;
            seq_phase = PH_GAP;
          end else begin
            seq_phase = PH_IDLE;
            seq_timer = '0;
            settled = 1'b1;
          end
        end
      endcase
    end
  endfunction

  // One tick of the sequencer; handled is low when the tick was swallowed by a busy sequence
  function automatic drive_t predict_tick(input logic hall_in, input logic photo,
                                          input logic [THR_W-1:0] smp, output bit handled);
    logic   hall;
    logic   fire;
    drive_t res;
    hall = hall_in;
    handled = 1'b1;
    if (seq_phase != PH_IDLE) begin
      if (hall) seq_hall_pend = 1'b1;
      seq_timer = seq_timer - 1'b1;
      if (seq_timer == 0) advance_phase();
      if (seq_phase != PH_IDLE) handled = 1'b0;
      else hall = 1'b0;
    end
    if (handled) begin
      hall = hall | seq_hall_pend;
      seq_hall_pend = 1'b0;
      if (hall && seq_count != COUNT_TOP) seq_count = seq_count + 1'b1;
      if (photo != seq_present) begin
        seq_present = photo;
        seq_count = '0;
      end
      // lifter hysteresis
      if (smp <= set_lift) begin
        if (seq_lift != LIFT_ENGAGED) begin
          seq_lift = LIFT_ENGAGED;
          seq_suction_used = 1'b0;
          seq_lifter = 1'b1;
          seq_relay = 1'b0;
        end
      end else if (seq_lift != LIFT_RELEASED) begin
        seq_lift = LIFT_RELEASED;
        seq_lifter = 1'b0;
      end
      // one-shot cut at the start or end count
      if (!seq_cut_done &&
          ((seq_count == set_start && set_start_en && seq_present) ||
           (seq_count == set_end && set_end_en && !seq_present))) begin
        seq_cut_done = 1'b1;
        seq_relay = 1'b1;
        seq_phase = PH_RELAY;
        seq_timer = TIME_W'(1);
        n_cuts++;
      end
      if (seq_count == 0) seq_cut_done = 1'b0;
      // pedal one-shot suction
      fire = (smp >= set_pedal) && !seq_pedal_latch && seq_present && !seq_suction_used;
      if (fire) begin
        seq_pedal_latch = 1'b1;
        seq_suction_used = 1'b1;
        n_pedal++;
        if (seq_phase != PH_IDLE) begin
          seq_pedal_q = 1'b1;
        end else begin
          seq_phase = PH_GAP;
          advance_phase();
        end
      end else if (smp < set_pedal) begin
        seq_pedal_latch = 1'b0;
      end
    end
    if (seq_count > top_count_seen) top_count_seen = seq_count;
    res.cutter  = (seq_phase == PH_CUT);
    res.suction = (seq_phase == PH_SUCK);
    res.lifter  = seq_lifter;
    res.relay   = seq_relay;
    res.count   = seq_count;
    res.present = seq_present;
    res.busy    = (seq_phase != PH_IDLE);
    return res;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Drive one request and queue its result
  task automatic send_req(input logic hall, input logic photo, input logic [THR_W-1:0] smp,
                          input bit typed, input drive_t want, output bit handled);
    drive_t pred;
    due_t   d;
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_hall_edge    <= hall;
    in_photo_level  <= photo;
    in_pedal_sample <= smp;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pred = predict_tick(hall, photo, smp, handled);
    d.v = typed ? want : pred;
    d.tag = n_req;
    drives_due.push_back(d);
    n_req++;
  endtask

  // Stop sending and let every expected result come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_START_COUNT:  set_start    = val;
      REG_END_COUNT:    set_end      = val;
      REG_CUT_TIME:     set_cut      = val;
      REG_SUCTION_TIME: set_suck     = val;
      REG_START_EN:     set_start_en = val[0];
      REG_END_EN:       set_end_en   = val[0];
      REG_LIFT_THR:     set_lift     = val[THR_W-1:0];
      REG_PEDAL_THR:    set_pedal    = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] sc, input logic [15:0] ec,
                              input logic [15:0] ct, input logic [15:0] st,
                              input logic se, input logic ee,
                              input logic [THR_W-1:0] lt, input logic [THR_W-1:0] pt);
    wait_idle();
    write_reg(REG_START_COUNT, sc);
    write_reg(REG_END_COUNT, ec);
    write_reg(REG_CUT_TIME, ct);
    write_reg(REG_SUCTION_TIME, st);
    write_reg(REG_START_EN, {15'd0, se});
    write_reg(REG_END_EN, {15'd0, ee});
    write_reg(REG_LIFT_THR, {4'd0, lt});
    write_reg(REG_PEDAL_THR, {4'd0, pt});
  endtask

  // Random phase: objects pass the photo sensor while hall edges count, pedal wanders
  task automatic run_random(input int ph);
    logic [THR_W-1:0] lt, pt, smp;
    logic             photo;
    int               v, counted;
    bit               handled;
    counted = 0;
    gap_pct   = (ph < 2) ? 18 : (ph < 4) ? 64 : 0;
    stall_pct = (ph < 2) ? 64 : (ph < 4) ? 18 : 0;
    case (ph)
      1: begin lt = '0; pt = '1; end
      2: begin lt = '1; pt = '0; end
      3: begin
        lt = THR_W'($urandom_range(0, 4095));
        pt = THR_W'($urandom_range(0, 4095));
      end
      default: begin
        lt = THR_W'($urandom_range(50, 300));
        pt = THR_W'($urandom_range(600, 1200));
      end
    endcase
    program_regs(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                 $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, lt, pt);
    while (counted < PHASE_ITEMS) begin
      if ($urandom_range(0, 11) == 0) obj_lvl = !obj_lvl;
      // mostly clean photo level, occasional glitch
      photo = ($urandom_range(0, 29) == 0) ? !obj_lvl : obj_lvl;
      case ($urandom_range(0, 9))
        0, 1:    v = int'(set_lift) + int'($urandom_range(0, 4)) - 2;
        2, 3:    v = int'(set_pedal) + int'($urandom_range(0, 4)) - 2;
        4:       v = 0;
        5:       v = 4095;
        default: v = int'($urandom_range(0, 4095));
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      smp = v[THR_W-1:0];
      send_req($urandom_range(0, 99) < 60, photo, smp, 1'b0, NO_DRIVE, handled);
      counted++;
    end
    // run out any sequence still in progress before the next register change
    while (seq_phase != PH_IDLE)
      send_req(1'b1, seq_present, set_pedal, 1'b0, NO_DRIVE, handled);
  endtask

  // Result checker
  always @(posedge clk) begin
    due_t   d;
    drive_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.cutter  = out_cutter_drive;
      got.suction = out_suction_drive;
      got.lifter  = out_lifter_drive;
      got.relay   = out_relay_drive;
      got.count   = out_pulse_count;
      got.present = out_object_present;
      got.busy    = out_busy_res;
      if (drives_due.size() == 0) begin
        note_error($sformatf("tb_top: result with no request pending at %0t", $realtime));
      end else begin
        d = drives_due.pop_front();
        n_checked++;
        if (got.cutter !== d.v.cutter || got.suction !== d.v.suction ||
            got.lifter !== d.v.lifter || got.relay !== d.v.relay ||
            got.count !== d.v.count || got.present !== d.v.present ||
            got.busy !== d.v.busy)
          note_error($sformatf({"tb_top: request %0d mismatch (cut suck lift relay count obj busy)",
                                " expected %b %b %b %b %0d %b %b, got %b %b %b %b %0d %b %b"},
                               d.tag, d.v.cutter, d.v.suction, d.v.lifter, d.v.relay,
                               d.v.count, d.v.present, d.v.busy, got.cutter, got.suction,
                               got.lifter, got.relay, got.count, got.present, got.busy));
      end
    end
  end

  // Stimulus
  initial begin
    bit handled;
    bit seen_busy;
    int tail_n;
    n_req = 0; n_checked = 0; n_cuts = 0; n_pedal = 0; errors = 0;
    top_count_seen = '0;
    obj_lvl = 1'b0;
    clear_sequencer();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
      end else begin
        send_req(DIR_ROWS[i].hall, DIR_ROWS[i].photo, DIR_ROWS[i].smp,
                 DIR_ROWS[i].kind == ROW_TYPED, DIR_ROWS[i].want, handled);
      end
    end

    for (int ph = 0; ph < 6; ph++) run_random(ph);

    // one long cut at full rate, end count at all ones
    gap_pct = 0;
    stall_pct = 0;
    program_regs(16'd40, '1, 16'd40, 16'd40, 1'b1, 1'b0, '0, '1);
    // a photo change clears the count and rearms the cut
    send_req(1'b0, !seq_present, 12'd400, 1'b0, NO_DRIVE, handled);
    seen_busy = 1'b0;
    tail_n = 0;
    while (tail_n < 4) begin
      send_req(1'b1, 1'b1, 12'd400, 1'b0, NO_DRIVE, handled);
      if (seq_phase != PH_IDLE) seen_busy = 1'b1;
      else if (seen_busy) tail_n++;
    end

    wait_idle();
    $display("tb_top: %0d requests sent, %0d results checked, %0d mismatches",
             n_req, n_checked, errors);
    $display("tb_top: %0d cuts and %0d pedal suctions predicted, highest pulse count %0d",
             n_cuts, n_pedal, top_count_seen);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd40_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
